[rtl/rob_pkg.sv]
// Shared types and constants of the in-order reorder buffer.
package rob_pkg;

    // Fixed widths of the channel fields
    localparam int SEQ_W    = 32;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 32;

    // Most in-order results that one request may drain
    localparam int MAX_RESULTS = 64;
    localparam int BURST_W     = $clog2(MAX_RESULTS);

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_EMIT  = 2'd0,
        ST_STALE = 2'd1,
        ST_OVFL  = 2'd2,
        ST_DROP  = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_READ,
        S_HEAD,
        S_LOOK,
        S_EMIT
    } t_state;

endpackage

[rtl/rob_if.sv]
// Request and result channel interfaces of the reorder buffer.
interface rob_in_if;
    import rob_pkg::*;

    logic              valid;
    logic              ready;
    logic [SEQ_W-1:0]  seq_index;
    logic [DATA_W-1:0] item_data;

    modport source (output valid, output seq_index, output item_data, input ready);
    modport sink   (input valid, input seq_index, input item_data, output ready);
endinterface

interface rob_out_if;
    import rob_pkg::*;

    logic                valid;
    logic                ready;
    logic [SEQ_W-1:0]    out_index;
    logic [DATA_W-1:0]   out_data;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  emitted_total;
    logic                last;

    modport source (output valid, output out_index, output out_data, output status,
                    output emitted_total, output last, input ready);
    modport sink   (input valid, input out_index, input out_data, input status,
                    input emitted_total, input last, output ready);
endinterface

[rtl/in_order_reorder_buffer_core.sv]
// In-order reorder buffer: parks out-of-order requests in a WINDOW-slot ring of one RAM
// and emits them in sequence order. After reset the block runs a clearing pass over every
// slot of the ring RAM and is not ready meanwhile. A request is accepted only in the
// idle state. A rejected request (stale, overflow, or any request after a failure) gives
// one result. A parked request is written to its slot, then the ring head is read and
// checked; each in-order result it drains takes one RAM read on the single read port
// plus the output handshake, at most 64 results per request; leftovers drain on a later
// accepted request. The ring slot of next_expected + d is found by one add and compare.
module in_order_reorder_buffer_core #(
    parameter int WINDOW      = 64,
    parameter int DATA_WIDTH  = 64,
    parameter int INDEX_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rob_in_if.sink    i_in,
    rob_out_if.source o_out
);
    import rob_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam int RW = DATA_WIDTH + 1;

    // Sequencer and bookkeeping registers
    t_state                 r_state, n_state;
    logic [INDEX_WIDTH-1:0] r_next;
    logic [AW-1:0]          r_head;
    logic                   r_failed;
    logic [TOTAL_W-1:0]     r_count;
    logic [BURST_W-1:0]     r_burst;
    logic [AW-1:0]          r_clr;
    logic [INDEX_WIDTH-1:0] r_seq;
    logic [DATA_WIDTH-1:0]  r_data;
    logic                   r_fwd_clr;

    // Result register
    logic [SEQ_W-1:0]       r_o_index;
    logic [DATA_WIDTH-1:0]  r_o_data;
    t_status                r_o_status;
    logic [TOTAL_W-1:0]     r_o_total;
    logic                   r_o_last;

    // RAM port controls
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [RW-1:0]          w_wdata;
    logic                   w_re;
    logic [AW-1:0]          w_raddr;
    logic [RW-1:0]          w_rdata;

    logic [INDEX_WIDTH-1:0] w_dist;
    logic                   w_behind;
    logic                   w_in_win;
    logic [AW:0]            w_sum;
    logic [AW-1:0]          w_slot;
    logic [AW-1:0]          w_head_inc;
    logic [AW-1:0]          w_head_inc2;
    logic                   w_look_vld;
    logic                   w_out_hs;
    logic                   w_drain_hs;

    // Distance from next_expected and ring slot of the request
    assign w_dist   = r_seq - r_next;
    assign w_behind = w_dist[INDEX_WIDTH-1];
    assign w_in_win = !w_behind && (64'(w_dist) < 64'(WINDOW));
    assign w_sum    = {1'b0, r_head} + (AW+1)'(w_dist);
    assign w_slot   = (w_sum >= (AW+1)'(WINDOW)) ? AW'(w_sum - (AW+1)'(WINDOW)) : AW'(w_sum);

    // Ring pointer increments
    assign w_head_inc  = (r_head == AW'(WINDOW - 1)) ? '0 : r_head + 1'b1;
    assign w_head_inc2 = (w_head_inc == AW'(WINDOW - 1)) ? '0 : w_head_inc + 1'b1;

    // Drop a read that raced with the clear of the same slot
    assign w_look_vld = w_rdata[DATA_WIDTH] && !r_fwd_clr;

    assign w_out_hs   = (r_state == S_EMIT) && o_out.ready;
    assign w_drain_hs = w_out_hs && (r_o_status == ST_EMIT);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(WINDOW - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in.valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!r_failed && w_in_win) n_state = S_READ;
                else                       n_state = S_EMIT;
            end
            S_READ: begin
                n_state = S_HEAD;
            end
            S_HEAD: begin
                if (w_look_vld) n_state = S_LOOK;
                else            n_state = S_IDLE;
            end
            S_LOOK: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_hs) begin
                    if (r_o_last) n_state = S_IDLE;
                    else          n_state = S_LOOK;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Handshake and RAM controls
    always_comb begin
        i_in.ready  = (r_state == S_IDLE);
        o_out.valid = (r_state == S_EMIT);
        w_we        = 1'b0;
        w_waddr     = r_head;
        w_wdata     = '0;
        w_re        = 1'b0;
        w_raddr     = r_head;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
            end
            S_EVAL: begin
                if (!r_failed && w_in_win) begin
                    w_we    = 1'b1;
                    w_waddr = w_slot;
                    w_wdata = {1'b1, r_data};
                end
            end
            S_READ: begin
                w_re = 1'b1;
            end
            S_HEAD: begin
                w_re    = 1'b1;
                w_raddr = w_head_inc;
            end
            S_EMIT: begin
                if (w_drain_hs) begin
                    w_we    = 1'b1;
                    w_re    = !r_o_last;
                    w_raddr = w_head_inc2;
                end
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    // Drive result channel
    assign o_out.out_index     = r_o_index;
    assign o_out.out_data      = DATA_W'(r_o_data);
    assign o_out.status        = r_o_status;
    assign o_out.emitted_total = r_o_total;
    assign o_out.last          = r_o_last;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_next    <= '0;
            r_head    <= '0;
            r_failed  <= 1'b0;
            r_count   <= '0;
            r_burst   <= '0;
            r_fwd_clr <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fwd_clr <= w_we && w_re && (w_waddr == w_raddr);
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_EVAL) begin
                r_burst <= '0;
                if (!r_failed && !w_in_win && !w_behind) begin
                    r_failed <= 1'b1;
                end
            end
            // Advance the ring on each in-order result taken
            if (w_drain_hs) begin
                r_next  <= r_next + 1'b1;
                r_head  <= w_head_inc;
                r_count <= r_count + 1'b1;
                r_burst <= r_burst + 1'b1;
            end
        end
    end

    // Request capture and result payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_seq  <= INDEX_WIDTH'(i_in.seq_index);
            r_data <= DATA_WIDTH'(i_in.item_data);
        end
        case (r_state)
            S_EVAL: begin
                r_o_index <= SEQ_W'(r_seq);
                r_o_data  <= r_data;
                r_o_total <= r_count;
                r_o_last  <= 1'b1;
                if (r_failed)      r_o_status <= ST_DROP;
                else if (w_behind) r_o_status <= ST_STALE;
                else               r_o_status <= ST_OVFL;
            end
            S_HEAD: begin
                r_o_data <= w_rdata[DATA_WIDTH-1:0];
            end
            S_LOOK: begin
                r_o_index  <= SEQ_W'(r_next);
                r_o_total  <= r_count + 1'b1;
                r_o_status <= ST_EMIT;
                r_o_last   <= !w_look_vld || (r_burst == BURST_W'(MAX_RESULTS - 1));
            end
            S_EMIT: begin
                if (w_drain_hs && !r_o_last) begin
                    r_o_data <= w_rdata[DATA_WIDTH-1:0];
                end
            end
            default: begin
                r_o_last <= r_o_last;
            end
        endcase
    end

    // Ring storage: valid bit over data word
    rob_ram #(
        .WIDTH (RW),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );
endmodule

[rtl/rob_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module rob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold data while not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/rob_checker.sv]
// Port-level assertions of the reorder buffer and their bind to the top level.
module rob_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [rob_pkg::STATUS_W-1:0]    i_out_status,
    input logic                            i_out_last
);
    import rob_pkg::*;

    logic r_seen_fail;

    // Remember an overflow result once it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_fail <= 1'b0;
        end else if (i_out_valid && i_out_ready && (i_out_status == ST_OVFL)) begin
            r_seen_fail <= 1'b1;
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Rejected requests give exactly one result
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_EMIT) |-> i_out_last)
        else $error("rejected request without last");

    // No new request while a result waits
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("request taken while result pending");

    // After an overflow everything is dropped
    a_sticky_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_fail && i_out_valid |-> (i_out_status == ST_DROP))
        else $error("result after failure not dropped");
endmodule

bind in_order_reorder_buffer_core rob_checker u_rob_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_last   (o_out.last)
);
